>>> rtl/lrcs_pkg.sv
// Shared types and constants for the log record chain scanner.
package lrcs_pkg;

  localparam int OFFSET_BITS  = 40;
  localparam int HEADER_LEN   = 32;
  localparam int HDR_IDX_BITS = $clog2(HEADER_LEN);
  localparam int SEQ_BITS     = 64;
  localparam int MAGIC_BITS   = 32;
  localparam int KIND_BITS    = 8;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [OFFSET_BITS-1:0] CAPACITY_RESET   = OFFSET_BITS'(4096);
  localparam logic [MAGIC_BITS-1:0]  MAGIC_RESET      = '0;
  localparam logic [KIND_BITS-1:0]   KIND_FIRST_RESET = KIND_BITS'(1);
  localparam logic [KIND_BITS-1:0]   KIND_LAST_RESET  = KIND_BITS'(3);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LOG_CAPACITY = 2'd0,
    CFG_RECORD_MAGIC = 2'd1,
    CFG_KIND_FIRST   = 2'd2,
    CFG_KIND_LAST    = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_TRUNC   = 2'd1,
    STATUS_CORRUPT = 2'd2
  } scan_status_t;

  typedef enum logic {
    PHASE_HEADER = 1'b0,
    PHASE_BODY   = 1'b1
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } scan_in_t;

  typedef struct packed {
    logic [1:0]             scan_status;
    logic [OFFSET_BITS-1:0] scan_end_offset;
    logic [OFFSET_BITS-1:0] last_header_offset;
    logic [SEQ_BITS-1:0]    resume_sequence;
  } scan_out_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] log_capacity;
    logic [MAGIC_BITS-1:0]  record_magic;
    logic [KIND_BITS-1:0]   kind_first;
    logic [KIND_BITS-1:0]   kind_last;
  } scan_cfg_t;

endpackage

>>> rtl/lrcs_cfg.sv
// Configuration register file of the log record chain scanner.
module lrcs_cfg
  import lrcs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [CFG_IDX_BITS-1:0] wr_index,
  input  logic [OFFSET_BITS-1:0]  wr_data,
  output scan_cfg_t               cfg
);

  scan_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.log_capacity <= CAPACITY_RESET;
      regs.record_magic <= MAGIC_RESET;
      regs.kind_first   <= KIND_FIRST_RESET;
      regs.kind_last    <= KIND_LAST_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_LOG_CAPACITY: regs.log_capacity <= wr_data;
        CFG_RECORD_MAGIC: regs.record_magic <= wr_data[MAGIC_BITS-1:0];
        CFG_KIND_FIRST:   regs.kind_first   <= wr_data[KIND_BITS-1:0];
        CFG_KIND_LAST:    regs.kind_last    <= wr_data[KIND_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> rtl/lrcs_core.sv
// Scan state and per-byte step logic: header checks, chain checks, CRC-32C.
module lrcs_core
  import lrcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  scan_in_t  item,
  input  scan_cfg_t cfg,
  output logic      fire,
  output scan_out_t result
);

  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int          HDR_BITS = HEADER_LEN * 8;
  localparam logic [HDR_IDX_BITS-1:0] PREFIX_LAST = HDR_IDX_BITS'(3);
  localparam logic [HDR_IDX_BITS-1:0] HDR_LAST    = HDR_IDX_BITS'(HEADER_LEN - 1);

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Fewer than one header of room left at pos (or pos already past the end).
  function automatic logic boundary_hit(input logic [OFFSET_BITS-1:0] cap,
                                        input logic [OFFSET_BITS-1:0] at);
    return (at > cap) || ((cap - at) < OFFSET_BITS'(HEADER_LEN));
  endfunction

  // State
  logic [OFFSET_BITS-1:0]  pos, pos_next;
  logic [OFFSET_BITS-1:0]  rs, rs_next;
  logic [HDR_BITS-1:0]     hdr, hdr_next;
  logic [HDR_IDX_BITS-1:0] hidx, hidx_next;
  scan_phase_t             phase, phase_next;
  logic [31:0]             body_left, body_left_next;
  logic [31:0]             crc, crc_next;
  logic [OFFSET_BITS-1:0]  last, last_next;
  logic [SEQ_BITS-1:0]     aseq, aseq_next;
  logic                    finished, finished_next;

  // Header fields and derived values
  logic [HDR_BITS-1:0]    hdr_full, hdr_view;
  logic [MAGIC_BITS-1:0]  f_magic;
  logic [KIND_BITS-1:0]   f_kind;
  logic [23:0]            f_reserved;
  logic [SEQ_BITS-1:0]    f_seq, seq_inc;
  logic [31:0]            f_len, f_crc, crc_upd, left_dec;
  logic [63:0]            f_prev;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS:0]   hdr_end, cap_w, room;
  logic                   bad_header, over_room, bad_chain;
  logic                   stop, accept;
  logic [1:0]             stop_status;

  assign hdr_full = {hdr[HDR_BITS-9:0], item.data_byte};
  assign hdr_view = (phase == PHASE_HEADER) ? hdr_full : hdr;

  assign f_magic    = hdr_view[255:224];
  assign f_kind     = hdr_view[223:216];
  assign f_reserved = hdr_view[215:192];
  assign f_seq      = hdr_view[191:128];
  assign f_len      = hdr_view[127:96];
  assign f_crc      = hdr_view[95:64];
  assign f_prev     = hdr_view[63:0];

  assign seq_inc  = f_seq + SEQ_BITS'(1);
  assign pos_inc  = pos + OFFSET_BITS'(1);
  assign crc_upd  = crc32c_byte(crc, item.data_byte);
  assign left_dec = (body_left != '0) ? body_left - 32'd1 : '0;

  assign hdr_end = {1'b0, rs} + (OFFSET_BITS + 1)'(HEADER_LEN);
  assign cap_w   = {1'b0, cfg.log_capacity};
  assign room    = (cap_w >= hdr_end) ? cap_w - hdr_end : '0;

  assign bad_header = (f_magic != cfg.record_magic) || (f_kind < cfg.kind_first) ||
                      (f_kind > cfg.kind_last) || (f_reserved != '0);
  assign over_room  = (OFFSET_BITS + 1)'(f_len) > room;
  assign bad_chain  = ((rs != '0) && (f_prev != 64'(last))) ||
                      ((aseq != '0) && (seq_inc < aseq));

  always_comb begin
    pos_next       = pos;
    rs_next        = rs;
    hdr_next       = hdr;
    hidx_next      = hidx;
    phase_next     = phase;
    body_left_next = body_left;
    crc_next       = crc;
    last_next      = last;
    aseq_next      = aseq;
    finished_next  = finished;
    stop           = 1'b0;
    stop_status    = STATUS_OK;
    accept         = 1'b0;
    fire           = 1'b0;
    result         = '0;

    if (!finished) begin
      if (pos == '0 && phase == PHASE_HEADER && boundary_hit(cfg.log_capacity, pos)) begin
        stop        = 1'b1;
        stop_status = (pos == cfg.log_capacity) ? STATUS_OK : STATUS_TRUNC;
      end else if (phase == PHASE_HEADER) begin
        hdr_next  = hdr_full;
        hidx_next = hidx + HDR_IDX_BITS'(1);
        pos_next  = pos_inc;
        if (hidx == PREFIX_LAST && hdr_full[31:0] == '0) begin
          stop        = 1'b1;
          stop_status = STATUS_OK;
        end else if (hidx == HDR_LAST) begin
          if (bad_header) begin
            stop        = 1'b1;
            stop_status = STATUS_CORRUPT;
          end else if (over_room) begin
            stop        = 1'b1;
            stop_status = STATUS_TRUNC;
          end else if (bad_chain || f_seq == '1) begin
            stop        = 1'b1;
            stop_status = STATUS_CORRUPT;
          end else if (f_len == '0) begin
            if (f_crc != '0) begin
              stop        = 1'b1;
              stop_status = STATUS_CORRUPT;
            end else begin
              accept = 1'b1;
            end
          end else begin
            phase_next     = PHASE_BODY;
            body_left_next = f_len;
            crc_next       = CRC_INIT;
          end
        end
      end else begin
        crc_next       = crc_upd;
        pos_next       = pos_inc;
        body_left_next = left_dec;
        if (left_dec == '0) begin
          if (~crc_upd != f_crc) begin
            stop        = 1'b1;
            stop_status = STATUS_CORRUPT;
          end else begin
            accept = 1'b1;
          end
        end
      end
    end

    // Close the record and check room for the next header
    if (accept) begin
      last_next  = rs;
      if (seq_inc > aseq) begin
        aseq_next = seq_inc;
      end
      rs_next    = pos_inc;
      phase_next = PHASE_HEADER;
      hidx_next  = '0;
      if (boundary_hit(cfg.log_capacity, pos_inc)) begin
        stop        = 1'b1;
        stop_status = (pos_inc == cfg.log_capacity) ? STATUS_OK : STATUS_TRUNC;
      end
    end

    if (stop) begin
      finished_next = 1'b1;
      fire          = 1'b1;
    end
    if (item.final_byte && !finished_next) begin
      fire        = 1'b1;
      stop_status = STATUS_TRUNC;
    end

    result.scan_status        = stop_status;
    result.scan_end_offset    = rs_next;
    result.last_header_offset = last_next;
    result.resume_sequence    = aseq_next;

    // End of stream: re-arm for a new scan, keep the registers
    if (item.final_byte) begin
      pos_next       = '0;
      rs_next        = '0;
      hidx_next      = '0;
      phase_next     = PHASE_HEADER;
      body_left_next = '0;
      crc_next       = CRC_INIT;
      last_next      = '0;
      aseq_next      = '0;
      finished_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      rs        <= '0;
      hidx      <= '0;
      phase     <= PHASE_HEADER;
      body_left <= '0;
      crc       <= CRC_INIT;
      last      <= '0;
      aseq      <= '0;
      finished  <= 1'b0;
    end else if (step) begin
      pos       <= pos_next;
      rs        <= rs_next;
      hidx      <= hidx_next;
      phase     <= phase_next;
      body_left <= body_left_next;
      crc       <= crc_next;
      last      <= last_next;
      aseq      <= aseq_next;
      finished  <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hdr <= hdr_next;
    end
  end

`ifndef SYNTHESIS
  a_idx_only_in_header: assert property (@(posedge clk) disable iff (rst)
    (hidx != '0) |-> (phase == PHASE_HEADER))
    else $error("header index nonzero outside header phase");

  a_body_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PHASE_BODY && !finished) |-> (body_left != '0))
    else $error("body phase with no bytes left");

  a_header_tracks_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == PHASE_HEADER && !finished) |-> ((pos - rs) == OFFSET_BITS'(hidx)))
    else $error("header index out of step with byte position");

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    (step && finished && !item.final_byte) |=> finished)
    else $error("stopped scan restarted without end of stream");
`endif

endmodule

>>> rtl/log_record_chain_scanner.sv
// Top level of the log record chain scanner: channels, input and result registers.
//
//   channel   direction  handshake                payload
//   item      in         item_valid / item_ready  scan_in_t  (data_byte, final_byte)
//   result    out        result_valid / result_ready  scan_out_t (status, offsets, seq)
//   cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One byte is taken every cycle unless a held result stalls the input. A transfer
// lands in the input register, the step logic of the core runs on it once the
// result register can take a result, and any result lands in the result register
// at the edge that ends that step.
// The CRC-32C byte update and the header compares in the core set the cycle.
// A held result (result_valid high, result_ready low) holds the input register;
// item_ready then drops once that register is full. Reset is synchronous and
// clears the scan state, both valid flags and the configuration registers;
// there is no clearing pass, the header buffer needs none. cfg_ready is always
// high.
module log_record_chain_scanner
  import lrcs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  scan_in_t                item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output scan_out_t               result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [OFFSET_BITS-1:0]  cfg_data
);

  scan_cfg_t cfg;
  scan_in_t  in_q;
  logic      in_full;
  logic      out_free;
  logic      step;
  logic      core_fire;
  scan_out_t core_result;

  // Configuration writes are never back-pressured
  assign cfg_ready = 1'b1;

  lrcs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held byte only when the result register can take a result
  assign out_free   = !result_valid || result_ready;
  assign step       = in_full && out_free;
  assign item_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_q <= item;
    end
  end

  lrcs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_q),
    .cfg    (cfg),
    .fire   (core_fire),
    .result (core_result)
  );

  // Result register: load on a step that stops the scan or ends the stream mid-scan, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step && core_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step && core_fire) begin
      result <= core_result;
    end
  end

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the log record chain scanner: stimulus, prediction and checks.
module tb_top;
  import lrcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Cycles to let the core finish an item that produced no report.
  localparam int SETTLE_CYCLES = 6;
  localparam logic [63:0] HDR64 = 64'(HEADER_LEN);

  // How a generated log is damaged, if at all.
  typedef enum int {
    FLAW_NONE,
    FLAW_ZERO_END,
    FLAW_FILL,
    FLAW_EARLY_END,
    FLAW_BAD_MAGIC,
    FLAW_BAD_KIND,
    FLAW_BAD_RSVD,
    FLAW_OVERRUN,
    FLAW_BAD_PREV,
    FLAW_SEQ_BACK,
    FLAW_SEQ_MAX,
    FLAW_BAD_CRC,
    FLAW_EMPTY_CRC,
    FLAW_NOISE
  } flaw_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_ready;
  scan_in_t                item = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  scan_out_t               result;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [OFFSET_BITS-1:0]  cfg_data = '0;

  always #1 clk = ~clk;

  log_record_chain_scanner u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Bytes waiting to be offered, and reports the scanner still owes us.
  scan_in_t  pending_bytes[$];
  scan_out_t expected_reports[$];

  // Shadow of the configuration registers, updated on each accepted write.
  logic [OFFSET_BITS-1:0] cap;
  logic [MAGIC_BITS-1:0]  magic;
  logic [KIND_BITS-1:0]   kf;
  logic [KIND_BITS-1:0]   kl;

  // Shadow of the scan state.
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] rec_start;
  logic [7:0]             hdr [HEADER_LEN];
  scan_phase_t            phase;
  logic [31:0]            body_left;
  logic [31:0]            crc;
  logic [OFFSET_BITS-1:0] last_ok;
  logic [SEQ_BITS-1:0]    next_seq;
  bit                     scan_done;

  int idle_pct = 15;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int err_cnt = 0;
  int bytes_in = 0;
  int bytes_queued = 0;
  int scans_built = 0;
  int directed_scans = 0;
  int cfg_writes = 0;
  int status_seen [4] = '{default: 0};

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Castagnoli CRC, reflected, one byte at a time.
  function automatic logic [31:0] crc32c_byte(logic [31:0] c, logic [7:0] b);
    c ^= {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'h82F6_3B78) : (c >> 1);
    end
    return c;
  endfunction

  // Big-endian field out of the captured header.
  function automatic logic [63:0] hdr_field(int at, int count);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < count; i++) begin
      v = (v << 8) | {56'b0, hdr[at + i]};
    end
    return v;
  endfunction

  // Start a fresh scan from offset zero; registers stay as they are.
  function automatic void rearm_scan();
    pos       = '0;
    rec_start = '0;
    phase     = PHASE_HEADER;
    body_left = '0;
    crc       = '1;
    last_ok   = '0;
    next_seq  = '0;
    scan_done = 1'b0;
  endfunction

  // Close the scan and queue the report it owes.
  function automatic void log_stop(scan_status_t st);
    scan_out_t r;
    r.scan_status        = st;
    r.scan_end_offset    = rec_start;
    r.last_header_offset = last_ok;
    r.resume_sequence    = next_seq;
    expected_reports.push_back(r);
    scan_done = 1'b1;
  endfunction

  // Stop when less than a header fits in what is left of the region.
  function automatic void check_boundary();
    if (pos > cap || (cap - pos) < OFFSET_BITS'(HEADER_LEN)) begin
      if (pos == cap) log_stop(STATUS_OK);
      else log_stop(STATUS_TRUNC);
    end
  endfunction

  function automatic void close_record();
    logic [63:0] s;
    s = hdr_field(8, 8);
    last_ok = rec_start;
    if (s + 64'd1 > next_seq) next_seq = s + 64'd1;
    rec_start = pos;
    phase = PHASE_HEADER;
    check_boundary();
  endfunction

  // All header bytes are in: run the header, room and chain checks.
  function automatic void header_complete();
    logic [63:0] len, s, s1, prev, room, cap64, rs64;
    len   = hdr_field(16, 4);
    s     = hdr_field(8, 8);
    s1    = s + 64'd1;
    prev  = hdr_field(24, 8);
    cap64 = {24'b0, cap};
    rs64  = {24'b0, rec_start};
    room  = '0;
    if (hdr_field(0, 4) != {32'b0, magic} || hdr[4] < kf || hdr[4] > kl ||
        hdr[5] != 8'h00 || hdr[6] != 8'h00 || hdr[7] != 8'h00) begin
      log_stop(STATUS_CORRUPT);
    end else begin
      if (cap64 >= rs64 + HDR64) room = cap64 - rs64 - HDR64;
      if (len > room) begin
        log_stop(STATUS_TRUNC);
      end else if ((rec_start != '0 && prev != {24'b0, last_ok}) ||
                   (next_seq != '0 && s1 < next_seq)) begin
        log_stop(STATUS_CORRUPT);
      end else if (s == '1) begin
        log_stop(STATUS_CORRUPT);
      end else if (len == '0) begin
        if (hdr_field(20, 4) != '0) log_stop(STATUS_CORRUPT);
        else close_record();
      end else begin
        phase     = PHASE_BODY;
        body_left = len[31:0];
        crc       = '1;
      end
    end
  endfunction

  // Advance the shadow scan by one accepted byte.
  function automatic void scan_byte(scan_in_t it);
    logic [OFFSET_BITS-1:0] idx;
    logic [31:0]            want_crc;
    if (!scan_done) begin
      if (pos == '0 && phase == PHASE_HEADER) check_boundary();
      if (!scan_done) begin
        if (phase == PHASE_HEADER) begin
          idx = pos - rec_start;
          hdr[idx[4:0]] = it.data_byte;
          pos = pos + 1'b1;
          if (idx == 3 && hdr_field(0, 4) == '0) log_stop(STATUS_OK);
          else if (idx >= OFFSET_BITS'(HEADER_LEN - 1)) header_complete();
        end else begin
          crc = crc32c_byte(crc, it.data_byte);
          pos = pos + 1'b1;
          if (body_left != '0) body_left = body_left - 1'b1;
          if (body_left == '0) begin
            want_crc = 32'(hdr_field(20, 4));
            if (~crc != want_crc) log_stop(STATUS_CORRUPT);
            else close_record();
          end
        end
      end
    end
    // End of stream: report truncation if still scanning, then rearm.
    if (it.final_byte) begin
      if (!scan_done) log_stop(STATUS_TRUNC);
      rearm_scan();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Log generator
  // ---------------------------------------------------------------------------

  function automatic void push_be(ref logic [7:0] q[$], input logic [63:0] v,
                                  input int count);
    for (int i = count - 1; i >= 0; i--) begin
      q.push_back(v[8*i +: 8]);
    end
  endfunction

  // Build one log region as a chain of records against the current registers,
  // damage it as asked, and queue its bytes with the last one marked final.
  function automatic void build_scan(flaw_t flaw);
    logic [7:0]  q[$];
    logic [7:0]  body[$];
    logic [63:0] cap64, pos64, room, seq, prev_seq, prev_off, prev_field;
    logic [31:0] len, crc_acc, crc_field, mg;
    logic [7:0]  kind, b;
    logic [7:0]  rsvd [3];
    int          n_rec, flaw_rec, min_rec, tries, back, cut;
    scan_in_t    it;
    cap64    = {24'b0, cap};
    pos64    = '0;
    prev_off = '0;
    prev_seq = '0;
    min_rec  = (flaw == FLAW_BAD_PREV || flaw == FLAW_SEQ_BACK) ? 1 : 0;
    n_rec    = (flaw == FLAW_FILL) ? 12 : (flaw == FLAW_NOISE) ? 0 : $urandom_range(0, 3);
    if (flaw == FLAW_EARLY_END && n_rec == 0) n_rec = 1;
    flaw_rec = -1;
    if (flaw >= FLAW_BAD_MAGIC && flaw <= FLAW_EMPTY_CRC) begin
      if (n_rec < min_rec + 1) n_rec = min_rec + 1;
      flaw_rec = $urandom_range(min_rec, n_rec - 1);
    end
    case ($urandom_range(0, 9))
      0:       seq = {$urandom, $urandom};
      1:       seq = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(1, 6));
      default: seq = 64'($urandom_range(0, 1000));
    endcase

    for (int i = 0; i < n_rec; i++) begin
      if (pos64 > cap64 || cap64 - pos64 < HDR64) break;
      room = cap64 - pos64 - HDR64;
      len = $urandom_range(0, 8);
      if (room < {32'b0, len}) len = room[31:0];
      // Now and then size the body to land exactly on the end of the region.
      if (room <= 40 && (flaw == FLAW_FILL || $urandom_range(0, 3) == 0)) len = room[31:0];
      if (i > 0) seq = seq + 64'($urandom_range(0, 2));
      mg         = magic;
      kind       = 8'($urandom_range(kf, kl));
      rsvd       = '{default: 8'h00};
      prev_field = (i == 0) ? {$urandom, $urandom} : prev_off;
      if (i == flaw_rec) begin
        case (flaw)
          FLAW_BAD_MAGIC: mg = magic ^ (32'd1 << $urandom_range(0, 31));
          FLAW_BAD_KIND: begin
            tries = 0;
            do begin
              kind = 8'($urandom_range(0, 255));
              tries++;
            end while (kf <= kl && kind >= kf && kind <= kl && tries < 64);
          end
          FLAW_BAD_RSVD: rsvd[$urandom_range(0, 2)] = 8'($urandom_range(1, 255));
          FLAW_OVERRUN:  if (room < 64'hFFFF_FFFF) len = room[31:0] + 1'b1;
          FLAW_BAD_PREV: prev_field = prev_off ^ (64'd1 << $urandom_range(0, 63));
          FLAW_SEQ_BACK: begin
            if (prev_seq != '0) begin
              back = (prev_seq > 5) ? 5 : int'(prev_seq);
              seq  = prev_seq - 64'($urandom_range(1, back));
            end
          end
          FLAW_SEQ_MAX:   seq = '1;
          FLAW_BAD_CRC:   if (len == '0 && room != '0) len = 32'd1;
          FLAW_EMPTY_CRC: len = '0;
          default: ;
        endcase
      end

      // Body bytes, leaning on the extreme values; none behind an overrun.
      body.delete();
      crc_acc = '1;
      if (!(i == flaw_rec && flaw == FLAW_OVERRUN)) begin
        for (int k = 0; k < int'(len); k++) begin
          case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
          endcase
          body.push_back(b);
          crc_acc = crc32c_byte(crc_acc, b);
        end
      end
      crc_field = ~crc_acc;
      if (i == flaw_rec && flaw == FLAW_BAD_CRC) crc_field ^= 32'd1 << $urandom_range(0, 31);
      if (i == flaw_rec && flaw == FLAW_EMPTY_CRC) crc_field = $urandom | 32'd1;

      push_be(q, {32'b0, mg}, 4);
      q.push_back(kind);
      foreach (rsvd[r]) q.push_back(rsvd[r]);
      push_be(q, seq, 8);
      push_be(q, {32'b0, len}, 4);
      push_be(q, {32'b0, crc_field}, 4);
      push_be(q, prev_field, 8);
      foreach (body[k]) q.push_back(body[k]);
      prev_off = pos64;
      prev_seq = seq;
      pos64    = pos64 + HDR64 + {32'b0, len};
      if (i == flaw_rec) break;
    end

    // Tail: a zero prefix that ends the log, loose noise, or nothing.
    if (flaw == FLAW_ZERO_END) begin
      push_be(q, 64'd0, 4);
      repeat ($urandom_range(0, 5)) q.push_back(8'($urandom_range(0, 255)));
    end else if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 40)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0: push_be(q, 64'd0, 4);
        1: repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    // Cut the stream short so that it ends in the middle of the scan.
    if (flaw == FLAW_EARLY_END || $urandom_range(0, 9) == 0) begin
      if (q.size() > 1) begin
        cut = $urandom_range(0, q.size() - 2);
        q = q[0:cut];
      end
    end
    if (q.size() == 0) q.push_back(8'($urandom_range(0, 255)));

    foreach (q[k]) begin
      it.data_byte  = q[k];
      it.final_byte = (k == q.size() - 1);
      pending_bytes.push_back(it);
    end
    bytes_queued += q.size();
    scans_built++;
  endfunction

  function automatic flaw_t pick_flaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return FLAW_NONE;
    if (r < 55) return FLAW_ZERO_END;
    if (r < 60) return FLAW_FILL;
    return flaw_t'($urandom_range(FLAW_EARLY_END, FLAW_NOISE));
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: offer queued bytes, hold each until its transfer, and now and
  // then drop valid for a random gap.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left = 0;
    end else if (!item_valid || item_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        item       <= pending_bytes.pop_front();
        item_valid <= 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 3);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Report sink: stall ready in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 2);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: advance the shadow scan on each byte transfer, then match each
  // report transfer against the oldest expected report, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    scan_out_t want;
    if (rst) begin
      rearm_scan();
      idle_cycles = 0;
    end else begin
      if (item_valid && item_ready) begin
        bytes_in++;
        scan_byte(item);
      end
      if (result_valid && result_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report with none expected: status %0d end %0h", result.scan_status,
                 result.scan_end_offset);
          err_cnt++;
        end else begin
          want = expected_reports.pop_front();
          status_seen[want.scan_status]++;
          if (result.scan_status !== want.scan_status) begin
            $error("scan_status: expected %0d, actual %0d", want.scan_status,
                   result.scan_status);
            err_cnt++;
          end
          if (result.scan_end_offset !== want.scan_end_offset) begin
            $error("scan_end_offset: expected %0h, actual %0h", want.scan_end_offset,
                   result.scan_end_offset);
            err_cnt++;
          end
          if (result.last_header_offset !== want.last_header_offset) begin
            $error("last_header_offset: expected %0h, actual %0h", want.last_header_offset,
                   result.last_header_offset);
            err_cnt++;
          end
          if (result.resume_sequence !== want.resume_sequence) begin
            $error("resume_sequence: expected %0h, actual %0h", want.resume_sequence,
                   result.resume_sequence);
            err_cnt++;
          end
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Hang detection: give up after a long stretch without any transfer.
  initial begin : watchdog
    do @(negedge clk); while (idle_cycles < STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Write one register and mirror it once the transfer completes.
  task automatic write_reg(cfg_index_t idx, logic [OFFSET_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LOG_CAPACITY: cap   = val;
      CFG_RECORD_MAGIC: magic = val[MAGIC_BITS-1:0];
      CFG_KIND_FIRST:   kf    = val[KIND_BITS-1:0];
      CFG_KIND_LAST:    kl    = val[KIND_BITS-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [OFFSET_BITS-1:0] c, logic [MAGIC_BITS-1:0] m,
                           logic [KIND_BITS-1:0] f, logic [KIND_BITS-1:0] l);
    write_reg(CFG_LOG_CAPACITY, c);
    write_reg(CFG_RECORD_MAGIC, {8'b0, m});
    write_reg(CFG_KIND_FIRST, {32'b0, f});
    write_reg(CFG_KIND_LAST, {32'b0, l});
  endtask

  // Hold until every queued byte is in and every report is out, then let the
  // core settle so a trailing byte with no report cannot see a register write.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || item_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue random logs; sometimes pause the sender until the scanner is empty.
  task automatic random_scans(int n);
    repeat (n) begin
      @(negedge clk);
      build_scan(pick_flaw());
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin : stimulus
    flaw_t            f;
    logic [39:0]      c;
    logic [7:0]       first;
    int               pick;
    cap   = CAPACITY_RESET;
    magic = MAGIC_RESET;
    kf    = KIND_FIRST_RESET;
    kl    = KIND_LAST_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset values: zero magic makes every header look
    // like the zero end marker.
    idle_pct = 15;
    random_scans(2);

    // Directed: one log per way a scan can end.
    configure(40'd200, 32'hA5C3_0F1E, 8'd1, 8'd3);
    idle_pct = 20;
    f = f.first();
    do begin
      @(negedge clk);
      build_scan(f);
      directed_scans++;
      f = f.next();
    end while (f != f.first());
    wait_drained();

    // Register extremes: smallest region, all-ones magic, full kind range.
    configure(40'd32, 32'hFFFF_FFFF, 8'd0, 8'd255);
    random_scans(2);
    // Largest region, single top kind.
    configure(40'hFF_FFFF_FFFF, $urandom, 8'd255, 8'd255);
    idle_pct = 10;
    random_scans(2);
    // Empty kind range: every header is corrupt.
    configure(40'($urandom_range(33, 300)), $urandom, 8'd9, 8'd4);
    idle_pct = 25;
    random_scans(2);
    configure(40'($urandom_range(64, 400)), 32'h0, 8'd0, 8'd0);
    idle_pct = 10;
    random_scans(2);

    // Random settings until enough bytes and reports have gone through.
    while (bytes_queued < 1400 || scans_built < 28) begin
      case ($urandom_range(0, 5))
        0:       c = {8'($urandom_range(0, 255)), 32'($urandom)};
        1:       c = 40'd32;
        default: c = 40'($urandom_range(33, 400));
      endcase
      if (c < 40'd32) c = 40'd32;
      first = 8'($urandom_range(0, 6));
      pick  = $urandom_range(0, 2);
      idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
      configure(c, $urandom, first,
                ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 6)) :
                                              first + 8'($urandom_range(0, 4)));
      random_scans(2);
    end

    // Last stretch at full rate on both sides.
    idle_pct = 0;
    configure(40'd160, $urandom, 8'd1, 8'd3);
    random_scans(3);

    $display("Covered %0d logs (%0d directed), %0d bytes in, %0d register writes",
             scans_built, directed_scans, bytes_in, cfg_writes);
    $display("Reports: %0d ok, %0d truncated, %0d corrupt",
             status_seen[STATUS_OK], status_seen[STATUS_TRUNC], status_seen[STATUS_CORRUPT]);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lrcs_pkg.sv
rtl/lrcs_cfg.sv
rtl/lrcs_core.sv
rtl/log_record_chain_scanner.sv
bench/tb_top.sv
